>>> rtl/sbl_pkg.sv
// Shared types and constants for the spectrum band LED strip driver.
// No dependencies; used by sbl_line and spectrum_band_led_strip_driver.
package sbl_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_BASS_EDGE   = 3'd0;
  localparam logic [2:0] REG_TREBLE_EDGE = 3'd1;
  localparam logic [2:0] REG_LED_COUNT   = 3'd2;
  localparam logic [2:0] REG_ONE_HIGH    = 3'd3;
  localparam logic [2:0] REG_ONE_LOW     = 3'd4;
  localparam logic [2:0] REG_ZERO_HIGH   = 3'd5;
  localparam logic [2:0] REG_ZERO_LOW    = 3'd6;
  localparam logic [2:0] REG_LATCH_LOW   = 3'd7;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned COLOUR_W = 24;
  localparam logic [4:0] LAST_BIT  = 5'd23;

  // reset values of the registers
  localparam logic [7:0]  RST_BASS_EDGE   = 8'd6;
  localparam logic [7:0]  RST_TREBLE_EDGE = 8'd25;
  localparam logic [9:0]  RST_LED_COUNT   = 10'd30;
  localparam logic [7:0]  RST_ONE_HIGH    = 8'd26;
  localparam logic [7:0]  RST_ONE_LOW     = 8'd14;
  localparam logic [7:0]  RST_ZERO_HIGH   = 8'd13;
  localparam logic [7:0]  RST_ZERO_LOW    = 8'd27;
  localparam logic [15:0] RST_LATCH_LOW   = 16'd1600;

  typedef struct packed {
    logic [9:0]  led_count;
    logic [7:0]  one_high_ticks;
    logic [7:0]  one_low_ticks;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  zero_low_ticks;
    logic [15:0] latch_low_ticks;
  } line_cfg_t;

  typedef struct packed {
    logic line_level;
    logic frame_done;
    logic sending;
  } line_res_t;

endpackage

>>> rtl/sbl_line.sv
// Strip line engine: reset period, then the 24-bit colour word per LED, bit timing by tick.
// Depends on sbl_pkg.
module sbl_line import sbl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  line_cfg_t           cfg,
  input  logic                tick_en,
  input  logic                take_en,
  input  logic [COLOUR_W-1:0] take_colour,
  output line_res_t           res
);

  phase_t              phase, phase_next;
  logic [COLOUR_W-1:0] active_colour, active_colour_next;
  logic [COLOUR_W-1:0] waiting_colour, waiting_colour_next;
  logic                waiting_flag, waiting_flag_next;
  logic [9:0]          leds_left, leds_left_next;
  logic [4:0]          bit_position, bit_position_next;
  logic [15:0]         tick_count, tick_count_next;

  logic [16:0] tick_inc;
  logic [16:0] limit;
  logic        cur_bit;
  logic        period_end;
  logic [9:0]  leds_dec;
  logic [4:0]  bit_index;
  logic [31:0] colour_wide;
  logic        frame_end;

  assign bit_index   = LAST_BIT - bit_position;
  assign colour_wide = {8'd0, active_colour};
  assign cur_bit     = colour_wide[bit_index];
  assign tick_inc    = {1'b0, tick_count} + 17'd1;
  assign leds_dec    = leds_left - 10'd1;

  always_comb begin
    case (phase)
      PH_RESET: limit = {1'b0, cfg.latch_low_ticks};
      PH_HIGH:  limit = cur_bit ? {9'd0, cfg.one_high_ticks} : {9'd0, cfg.zero_high_ticks};
      PH_LOW:   limit = cur_bit ? {9'd0, cfg.one_low_ticks} : {9'd0, cfg.zero_low_ticks};
      default:  limit = 17'd0;
    endcase
  end

  // a zero limit ends the period after one tick, as does a limit of one
  assign period_end = (tick_inc >= limit);
  assign frame_end  = tick_en && (phase == PH_LOW) && period_end
                      && (bit_position >= LAST_BIT) && (leds_dec == 10'd0);

  // next state
  always_comb begin
    phase_next          = phase;
    active_colour_next  = active_colour;
    waiting_colour_next = waiting_colour;
    waiting_flag_next   = waiting_flag;
    leds_left_next      = leds_left;
    bit_position_next   = bit_position;
    tick_count_next     = tick_count;
    if (take_en) begin
      if (phase == PH_IDLE) begin
        active_colour_next = take_colour;
        phase_next         = PH_RESET;
        tick_count_next    = 16'd0;
      end else begin
        waiting_colour_next = take_colour;
        waiting_flag_next   = 1'b1;
      end
    end else if (tick_en) begin
      case (phase)
        PH_RESET: begin
          if (period_end) begin
            tick_count_next   = 16'd0;
            phase_next        = PH_HIGH;
            bit_position_next = 5'd0;
            leds_left_next    = (cfg.led_count != 10'd0) ? cfg.led_count : 10'd1;
          end else begin
            tick_count_next = tick_inc[15:0];
          end
        end
        PH_HIGH: begin
          if (period_end) begin
            tick_count_next = 16'd0;
            phase_next      = PH_LOW;
          end else begin
            tick_count_next = tick_inc[15:0];
          end
        end
        PH_LOW: begin
          if (period_end) begin
            tick_count_next = 16'd0;
            if (bit_position >= LAST_BIT) begin
              bit_position_next = 5'd0;
              leds_left_next    = leds_dec;
              if (leds_dec == 10'd0) begin
                if (waiting_flag) begin
                  active_colour_next = waiting_colour;
                  waiting_flag_next  = 1'b0;
                  phase_next         = PH_RESET;
                end else begin
                  phase_next = PH_IDLE;
                end
              end else begin
                phase_next = PH_HIGH;
              end
            end else begin
              bit_position_next = bit_position + 5'd1;
              phase_next        = PH_HIGH;
            end
          end else begin
            tick_count_next = tick_inc[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  // outputs for the current tick
  always_comb begin
    res.line_level = (phase == PH_HIGH);
    res.sending    = (phase != PH_IDLE);
    res.frame_done = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_colour  <= '0;
      waiting_colour <= '0;
      waiting_flag   <= 1'b0;
      leds_left      <= '0;
      bit_position   <= '0;
      tick_count     <= '0;
    end else begin
      phase          <= phase_next;
      active_colour  <= active_colour_next;
      waiting_colour <= waiting_colour_next;
      waiting_flag   <= waiting_flag_next;
      leds_left      <= leds_left_next;
      bit_position   <= bit_position_next;
      tick_count     <= tick_count_next;
    end
  end

endmodule

>>> rtl/spectrum_band_led_strip_driver.sv
// Spectrum band LED strip driver: takes one item per clock unless in_stall,
// bins or line ticks; returns one result per tick. Uses sbl_pkg and sbl_line.
//
// Each accepted item is handled in the cycle it is taken: a bin updates the
// band sums, a tick steps the line engine, and the tick's result is registered
// in the output register, or in the skid behind a stalled one; the two form a
// two-entry output buffer. Items are taken every clock while in_stall is low;
// in_stall rises only once a second result waits behind a stalled one. The
// line engine reads led_count when a frame's data begins and the bit and reset
// timing on every tick, so registers are best written while the line is idle.
module spectrum_band_led_strip_driver import sbl_pkg::*; #(
  parameter int unsigned NUM_BINS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] left_level,
  input  logic signed [15:0] right_level,
  input  logic               last_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               line_level,
  output logic               frame_done,
  output logic               sending
);

  localparam logic [7:0] BinLimit = 8'(NUM_BINS);

  logic [7:0] bass_edge, treble_edge;
  line_cfg_t  cfg;
  logic [2:0] reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_edge           <= RST_BASS_EDGE;
      treble_edge         <= RST_TREBLE_EDGE;
      cfg.led_count       <= RST_LED_COUNT;
      cfg.one_high_ticks  <= RST_ONE_HIGH;
      cfg.one_low_ticks   <= RST_ONE_LOW;
      cfg.zero_high_ticks <= RST_ZERO_HIGH;
      cfg.zero_low_ticks  <= RST_ZERO_LOW;
      cfg.latch_low_ticks <= RST_LATCH_LOW;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BASS_EDGE:   bass_edge           <= pwdata[7:0];
        REG_TREBLE_EDGE: treble_edge         <= pwdata[7:0];
        REG_LED_COUNT:   cfg.led_count       <= pwdata[9:0];
        REG_ONE_HIGH:    cfg.one_high_ticks  <= pwdata[7:0];
        REG_ONE_LOW:     cfg.one_low_ticks   <= pwdata[7:0];
        REG_ZERO_HIGH:   cfg.zero_high_ticks <= pwdata[7:0];
        REG_ZERO_LOW:    cfg.zero_low_ticks  <= pwdata[7:0];
        REG_LATCH_LOW:   cfg.latch_low_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASS_EDGE:   prdata = {24'd0, bass_edge};
      REG_TREBLE_EDGE: prdata = {24'd0, treble_edge};
      REG_LED_COUNT:   prdata = {22'd0, cfg.led_count};
      REG_ONE_HIGH:    prdata = {24'd0, cfg.one_high_ticks};
      REG_ONE_LOW:     prdata = {24'd0, cfg.one_low_ticks};
      REG_ZERO_HIGH:   prdata = {24'd0, cfg.zero_high_ticks};
      REG_ZERO_LOW:    prdata = {24'd0, cfg.zero_low_ticks};
      REG_LATCH_LOW:   prdata = {16'd0, cfg.latch_low_ticks};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- band sums ----------------
  logic        in_xfer, bin_xfer, tick_xfer, take_en;
  logic [7:0]  bin_position, bin_position_next;
  logic [15:0] low_sum, mid_sum, high_sum;
  logic [15:0] low_sum_next, mid_sum_next, high_sum_next;
  logic [15:0] pair;
  logic [COLOUR_W-1:0] colour;

  assign in_xfer   = in_valid && !in_stall;
  assign bin_xfer  = in_xfer && !op;
  assign tick_xfer = in_xfer && op;
  assign take_en   = bin_xfer && last_bin;
  assign pair      = left_level + right_level;

  always_comb begin
    bin_position_next = bin_position;
    low_sum_next      = low_sum;
    mid_sum_next      = mid_sum;
    high_sum_next     = high_sum;
    if (bin_xfer && (bin_position < BinLimit)) begin
      if (bin_position < bass_edge) begin
        low_sum_next = low_sum + pair;
      end else if (bin_position < treble_edge) begin
        mid_sum_next = mid_sum + pair;
      end else begin
        high_sum_next = high_sum + pair;
      end
      bin_position_next = bin_position + 8'd1;
    end
  end

  // colour from the sums including the last bin itself
  assign colour = {high_sum_next[7:0], low_sum_next[8:1], mid_sum_next[8:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      low_sum      <= '0;
      mid_sum      <= '0;
      high_sum     <= '0;
    end else if (take_en) begin
      bin_position <= '0;
      low_sum      <= '0;
      mid_sum      <= '0;
      high_sum     <= '0;
    end else begin
      bin_position <= bin_position_next;
      low_sum      <= low_sum_next;
      mid_sum      <= mid_sum_next;
      high_sum     <= high_sum_next;
    end
  end

  line_res_t tick_res;

  sbl_line u_line (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .tick_en     (tick_xfer),
    .take_en     (take_en),
    .take_colour (colour),
    .res         (tick_res)
  );

  // ---------------- output register and skid ----------------
  logic      out_xfer;
  logic      skid_valid;
  line_res_t out_res, skid_res;

  assign out_xfer = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_xfer) begin
      out_valid  <= skid_valid || tick_xfer;
      skid_valid <= 1'b0;
    end else if (tick_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_res <= skid_valid ? skid_res : tick_res;
    end
    if (tick_xfer) begin
      skid_res <= tick_res;
    end
  end

  assign line_level = out_res.line_level;
  assign frame_done = out_res.frame_done;
  assign sending    = out_res.sending;

endmodule

>>> tb/sv/spectrum_band_led_strip_driver_tb.sv
// Self-checking testbench for spectrum_band_led_strip_driver: sends bin and tick
// transfers, predicts the line result of every tick and compares each output transfer.
// Depends on sbl_pkg and the driver RTL only.
module spectrum_band_led_strip_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbl_pkg::*;

  localparam int unsigned BIN_LIMIT = 128;
  localparam logic OP_BIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_BIN;
  logic signed [15:0] left_level = '0;
  logic signed [15:0] right_level = '0;
  logic               last_bin = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               line_level;
  logic               frame_done;
  logic               sending;

  // predicted block state and configuration
  logic [7:0]  mid_start = RST_BASS_EDGE;
  logic [7:0]  treble_start = RST_TREBLE_EDGE;
  line_cfg_t   line_cfg = '{RST_LED_COUNT, RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH,
                            RST_ZERO_LOW, RST_LATCH_LOW};
  logic [7:0]  bin_index = '0;
  logic [15:0] band_low_acc = '0;
  logic [15:0] band_mid_acc = '0;
  logic [15:0] band_high_acc = '0;
  logic [23:0] lit_colour = '0;
  logic [23:0] next_colour = '0;
  logic        next_colour_set = 1'b0;
  phase_t      strip_phase = PH_IDLE;
  logic [9:0]  leds_to_go = '0;
  logic [4:0]  bit_idx = '0;
  logic [15:0] phase_ticks = '0;

  line_res_t tick_results_q[$];
  int        fail_count = 0;
  bit        idle_on = 1'b0;
  bit        hold_outputs = 1'b0;

  spectrum_band_led_strip_driver #(.NUM_BINS(BIN_LIMIT)) u_dut (.*);

  always #5 clk = ~clk;

  function automatic void strip_bin(logic [15:0] lvl_l, logic [15:0] lvl_r, logic last);
    logic [15:0] pair;
    logic [23:0] colour;
    if (bin_index < BIN_LIMIT) begin
      pair = lvl_l + lvl_r;
      if (bin_index < mid_start) begin
        band_low_acc = band_low_acc + pair;
      end else if (bin_index < treble_start) begin
        band_mid_acc = band_mid_acc + pair;
      end else begin
        band_high_acc = band_high_acc + pair;
      end
      bin_index = bin_index + 8'd1;
    end
    if (last) begin
      colour = {band_high_acc[7:0], band_low_acc[8:1], band_mid_acc[8:1]};
      band_low_acc = '0;
      band_mid_acc = '0;
      band_high_acc = '0;
      bin_index = '0;
      if (strip_phase == PH_IDLE) begin
        lit_colour = colour;
        strip_phase = PH_RESET;
        phase_ticks = '0;
      end else begin
        // a newer colour replaces any one already waiting
        next_colour = colour;
        next_colour_set = 1'b1;
      end
    end
  endfunction

  function automatic line_res_t strip_tick();
    line_res_t  res;
    logic       one_bit;
    logic [7:0] limit;
    res.line_level = 1'b0;
    res.frame_done = 1'b0;
    res.sending = 1'b1;
    one_bit = lit_colour[LAST_BIT - bit_idx];
    case (strip_phase)
      PH_IDLE: res.sending = 1'b0;
      PH_RESET: begin
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= line_cfg.latch_low_ticks) begin
          phase_ticks = '0;
          strip_phase = PH_HIGH;
          bit_idx = '0;
          leds_to_go = (line_cfg.led_count == '0) ? 10'd1 : line_cfg.led_count;
        end
      end
      PH_HIGH: begin
        limit = one_bit ? line_cfg.one_high_ticks : line_cfg.zero_high_ticks;
        res.line_level = 1'b1;
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= limit) begin
          phase_ticks = '0;
          strip_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        limit = one_bit ? line_cfg.one_low_ticks : line_cfg.zero_low_ticks;
        phase_ticks = phase_ticks + 16'd1;
        if (phase_ticks >= limit) begin
          phase_ticks = '0;
          if (bit_idx == LAST_BIT) begin
            bit_idx = '0;
            leds_to_go = leds_to_go - 10'd1;
            if (leds_to_go == '0) begin
              res.frame_done = 1'b1;
              if (next_colour_set) begin
                lit_colour = next_colour;
                next_colour_set = 1'b0;
                strip_phase = PH_RESET;
              end else begin
                strip_phase = PH_IDLE;
              end
            end else begin
              strip_phase = PH_HIGH;
            end
          end else begin
            bit_idx = bit_idx + 5'd1;
            strip_phase = PH_HIGH;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] rand_level();
    logic [31:0] r;
    r = $urandom;
    case (r[31:29])
      3'd0: return 16'h7FFF;
      3'd1: return 16'h8000;
      3'd2: return 16'h0000;
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] reg_expect(logic [2:0] idx);
    case (idx)
      REG_BASS_EDGE:   return {24'd0, mid_start};
      REG_TREBLE_EDGE: return {24'd0, treble_start};
      REG_LED_COUNT:   return {22'd0, line_cfg.led_count};
      REG_ONE_HIGH:    return {24'd0, line_cfg.one_high_ticks};
      REG_ONE_LOW:     return {24'd0, line_cfg.one_low_ticks};
      REG_ZERO_HIGH:   return {24'd0, line_cfg.zero_high_ticks};
      REG_ZERO_LOW:    return {24'd0, line_cfg.zero_low_ticks};
      REG_LATCH_LOW:   return {16'd0, line_cfg.latch_low_ticks};
      default:         return 32'd0;
    endcase
  endfunction

  // write one register, then read it back
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASS_EDGE:   mid_start = val[7:0];
      REG_TREBLE_EDGE: treble_start = val[7:0];
      REG_LED_COUNT:   line_cfg.led_count = val[9:0];
      REG_ONE_HIGH:    line_cfg.one_high_ticks = val[7:0];
      REG_ONE_LOW:     line_cfg.one_low_ticks = val[7:0];
      REG_ZERO_HIGH:   line_cfg.zero_high_ticks = val[7:0];
      REG_ZERO_LOW:    line_cfg.zero_low_ticks = val[7:0];
      REG_LATCH_LOW:   line_cfg.latch_low_ticks = val[15:0];
      default: ;
    endcase
    want = reg_expect(idx);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high into the next call unless a gap is taken here
  task automatic send_item(logic kind, logic [15:0] lvl_l, logic [15:0] lvl_r, logic last);
    op <= kind;
    left_level <= lvl_l;
    right_level <= lvl_r;
    last_bin <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == OP_TICK) begin
      tick_results_q.push_back(strip_tick());
    end else begin
      strip_bin(lvl_l, lvl_r, last);
    end
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, rand_level(), rand_level(), $urandom_range(0, 1) != 0);
  endtask

  task automatic short_frame(int n);
    int k;
    for (k = 0; k < n; k++) send_item(OP_BIN, rand_level(), rand_level(), k == n - 1);
  endtask

  // let the output side empty; the line may still be mid-frame
  task automatic drain();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // finish any frame on the line, then let the output side empty
  task automatic quiesce();
    while (strip_phase != PH_IDLE) send_tick();
    drain();
  endtask

  task automatic set_edges(int unsigned mid_from, int unsigned treble_from);
    quiesce();
    reg_write(REG_BASS_EDGE, mid_from);
    reg_write(REG_TREBLE_EDGE, treble_from);
  endtask

  task automatic set_line_timing(int unsigned leds, int unsigned one_hi, int unsigned one_lo,
                                 int unsigned zero_hi, int unsigned zero_lo,
                                 int unsigned latch);
    quiesce();
    reg_write(REG_LED_COUNT, leds);
    reg_write(REG_ONE_HIGH, one_hi);
    reg_write(REG_ONE_LOW, one_lo);
    reg_write(REG_ZERO_HIGH, zero_hi);
    reg_write(REG_ZERO_LOW, zero_lo);
    reg_write(REG_LATCH_LOW, latch);
  endtask

  // bit timing changed under a frame; takes effect on the next tick
  task automatic set_bit_timing(int unsigned one_hi, int unsigned one_lo,
                                int unsigned zero_hi, int unsigned zero_lo);
    drain();
    reg_write(REG_ONE_HIGH, one_hi);
    reg_write(REG_ONE_LOW, one_lo);
    reg_write(REG_ZERO_HIGH, zero_hi);
    reg_write(REG_ZERO_LOW, zero_lo);
  endtask

  task automatic test_reset_config();
    int p;
    idle_on = 1'b1;
    send_tick();
    send_tick();
    // crosses both band edges at their reset positions
    for (p = 0; p < 27; p++) begin
      case (p % 3)
        0: send_item(OP_BIN, 16'h7FFF, 16'h7FFF, p == 26);
        1: send_item(OP_BIN, 16'h8000, 16'h8000, p == 26);
        default: send_item(OP_BIN, rand_level(), rand_level(), p == 26);
      endcase
    end
    // start of the reset period at its reset length, then cut it short
    repeat (40) send_tick();
    drain();
    reg_write(REG_LED_COUNT, 1);
    reg_write(REG_LATCH_LOW, 1);
    // first bits at the reset bit timing
    repeat (100) send_tick();
    set_bit_timing(1, 1, 1, 1);
    idle_on = 1'b0;
    quiesce();
  endtask

  task automatic test_band_edges();
    idle_on = 1'b1;
    set_line_timing(1, 1, 1, 1, 1, 1);
    set_edges(0, 0);
    short_frame(4);
    set_edges(255, 255);
    short_frame(4);
    // bass edge above treble edge: bass wins below it
    set_edges(10, 3);
    short_frame(12);
    set_edges(128, 128);
    short_frame(3);
  endtask

  task automatic test_pending_colour();
    idle_on = 1'b1;
    set_edges(2, 5);
    set_line_timing(1, 1, 1, 1, 1, 3);
    short_frame(6);
    repeat (5) send_tick();
    short_frame(6);
    repeat (3) send_tick();
    short_frame(7);
    quiesce();
  endtask

  task automatic test_bin_overflow();
    idle_on = 1'b1;
    short_frame(135);
    short_frame(1);
    quiesce();
  endtask

  task automatic test_zero_registers();
    idle_on = 1'b1;
    set_line_timing(0, 0, 0, 0, 0, 0);
    short_frame(5);
    quiesce();
  endtask

  task automatic test_line_extremes();
    idle_on = 1'b0;
    // longest high time: the first high period runs in full
    set_line_timing(1, 255, 255, 255, 255, 1);
    short_frame(8);
    repeat (260) send_tick();
    set_bit_timing(1, 1, 1, 1);
    quiesce();
    // longest reset period: only its start is run
    set_line_timing(1, 1, 1, 1, 1, 65535);
    short_frame(8);
    repeat (30) send_tick();
    drain();
    reg_write(REG_LATCH_LOW, 1);
    quiesce();
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    set_line_timing(1, 2, 1, 1, 2, 1);
    short_frame(3);
    hold_outputs = 1'b1;
    repeat (48) send_tick();
    quiesce();
  endtask

  task automatic test_random_traffic();
    int ph;
    int n;
    int k;
    int sent;
    for (ph = 0; ph < PHASES; ph++) begin
      set_edges(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 140),
                ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 140));
      set_line_timing($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 6));
      // no idling in the closing phase
      idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 4) begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 40);
          for (k = 0; k < n; k++) begin
            send_item(OP_BIN, rand_level(), rand_level(),
                      (k == n - 1) || ($urandom_range(0, 63) == 0));
            sent++;
            if ($urandom_range(0, 3) == 0) begin
              send_tick();
              sent++;
            end
          end
        end else begin
          n = $urandom_range(1, 60);
          repeat (n) send_tick();
          sent += n;
        end
      end
    end
    quiesce();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_outputs = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    line_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        $error("output transfer with no tick outstanding");
        fail_count++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("line_level", want.line_level, line_level);
        check_field("frame_done", want.frame_done, frame_done);
        check_field("sending", want.sending, sending);
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_band_edges();
    test_pending_colour();
    test_bin_overflow();
    test_zero_registers();
    test_line_extremes();
    test_output_hold();
    test_random_traffic();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (tick_results_q.size() != 0) begin
      $error("%0d tick results never arrived", tick_results_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
